>>> rtl/tce_pkg.sv
// Shared constants, types and helpers of the text console engine.
package tce_pkg;

  localparam int SCREEN_COLUMNS = 80;
  localparam int SCREEN_ROWS    = 25;
  localparam int CELL_COUNT     = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int ADDR_W         = $clog2(CELL_COUNT);
  localparam int ROW_W          = 5;
  localparam int COL_W          = 7;
  localparam int CELL_W         = 16;
  localparam int COPY_LAST      = SCREEN_COLUMNS * (SCREEN_ROWS - 1) - 1;
  localparam int LAST_CELL      = CELL_COUNT - 1;

  localparam logic [7:0] SPACE_CHAR   = 8'h20;
  localparam logic [7:0] CHAR_NL      = 8'h0A;
  localparam logic [7:0] CHAR_CR      = 8'h0D;
  localparam logic [7:0] CHAR_BS      = 8'h08;
  localparam logic [7:0] DEFAULT_ATTR = 8'h07;
  localparam logic [CELL_W-1:0] DEFAULT_CELL = {DEFAULT_ATTR, SPACE_CHAR};
  localparam logic [15:0] HIDDEN_LOCATION = 16'hFFFF;

  localparam logic [2:0] OP_PUT_BYTE   = 3'd0;
  localparam logic [2:0] OP_SET_CURSOR = 3'd1;
  localparam logic [2:0] OP_DRAW_CHAR  = 3'd2;
  localparam logic [2:0] OP_READ_CELL  = 3'd3;
  localparam logic [2:0] OP_CLEAR      = 3'd4;

  localparam logic REG_TEXT_ATTR    = 1'b0;
  localparam logic REG_CURSOR_SHOWN = 1'b1;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [CELL_W-1:0] data;
  } wr_req_t;

  typedef struct packed {
    logic             status;
    logic [7:0]       read_char;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } result_t;

  function automatic logic [ADDR_W-1:0] cell_index(input logic [ROW_W-1:0] r,
                                                   input logic [COL_W-1:0] c);
    return ADDR_W'(int'(r) * SCREEN_COLUMNS + int'(c));
  endfunction

endpackage

>>> rtl/text_console_engine.sv
// Top level of the text console engine: configuration port, output register, store.
//
//  channel   direction  handshake                     payload
//  item      in         item_valid / item_stall       opcode char_code row_in col_in
//                                                     cell_attribute
//  result    out        result_valid / result_stall   status read_char cursor_row
//                                                     cursor_col cursor_location
//  config    in         APB psel penable pwrite       paddr pwdata prdata
//
// Most items pass through accept and hand-off; cell reads and backspace add a state
// for the cell read. A scroll walks the store through the memory's write and read
// ports, copying each row up and blanking the bottom row; a clear writes every cell.
// After reset a clearing pass runs with item_stall high.
// A result waits in the output register while the next item is accepted; the block
// holds a finished item until that register is free.
module text_console_engine (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic [2:0]                    opcode,
  input  logic [7:0]                    char_code,
  input  logic [tce_pkg::ROW_W-1:0]     row_in,
  input  logic [tce_pkg::COL_W-1:0]     col_in,
  input  logic [7:0]                    cell_attribute,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic                          status,
  output logic [7:0]                    read_char,
  output logic [tce_pkg::ROW_W-1:0]     cursor_row,
  output logic [tce_pkg::COL_W-1:0]     cursor_col,
  output logic [15:0]                   cursor_location,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  logic                        text_attr;
  logic [7:0]                  text_attribute;
  logic                        cursor_shown;
  logic                        out_free;
  logic                        res_valid;
  tce_pkg::result_t            res;
  tce_pkg::wr_req_t            wr;
  logic [tce_pkg::ADDR_W-1:0]  raddr;
  logic [tce_pkg::CELL_W-1:0]  rdata;

  assign pready    = 1'b1;
  assign text_attr = (paddr[2] == tce_pkg::REG_TEXT_ATTR);
  assign prdata    = text_attr ? {24'h000000, text_attribute} : {31'h0, cursor_shown};

  always_ff @(posedge clk) begin
    if (rst) begin
      text_attribute <= tce_pkg::DEFAULT_ATTR;
      cursor_shown   <= 1'b1;
    end else if (psel && penable && pwrite && pready) begin
      if (text_attr) begin
        text_attribute <= pwdata[7:0];
      end else begin
        cursor_shown <= pwdata[0];
      end
    end
  end

  assign out_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_valid) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      status          <= res.status;
      read_char       <= res.read_char;
      cursor_row      <= res.row;
      cursor_col      <= res.col;
      cursor_location <= cursor_shown ? 16'(tce_pkg::cell_index(res.row, res.col))
                                      : tce_pkg::HIDDEN_LOCATION;
    end
  end

  tce_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .opcode         (opcode),
    .char_code      (char_code),
    .row_in         (row_in),
    .col_in         (col_in),
    .cell_attribute (cell_attribute),
    .text_attr      (text_attribute),
    .out_free       (out_free),
    .res_valid      (res_valid),
    .res            (res),
    .wr             (wr),
    .raddr          (raddr),
    .rdata          (rdata)
  );

  tce_cell_ram u_ram (
    .clk   (clk),
    .wr    (wr),
    .raddr (raddr),
    .rdata (rdata)
  );

endmodule

>>> rtl/tce_cell_ram.sv
// Screen cell store: one write port and one registered read port.
module tce_cell_ram (
  input  logic                          clk,
  input  tce_pkg::wr_req_t              wr,
  input  logic [tce_pkg::ADDR_W-1:0]    raddr,
  output logic [tce_pkg::CELL_W-1:0]    rdata
);

  logic [tce_pkg::CELL_W-1:0] mem [tce_pkg::CELL_COUNT];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/tce_ctrl.sv
// Operation sequencer: cursor state, cell read-modify-write, scroll and clear sweeps.
module tce_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic [2:0]                    opcode,
  input  logic [7:0]                    char_code,
  input  logic [tce_pkg::ROW_W-1:0]     row_in,
  input  logic [tce_pkg::COL_W-1:0]     col_in,
  input  logic [7:0]                    cell_attribute,
  input  logic [7:0]                    text_attr,
  input  logic                          out_free,
  output logic                          res_valid,
  output tce_pkg::result_t              res,
  output tce_pkg::wr_req_t              wr,
  output logic [tce_pkg::ADDR_W-1:0]    raddr,
  input  logic [tce_pkg::CELL_W-1:0]    rdata
);

  typedef enum logic [6:0] {
    S_INIT   = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_READ   = 7'b0000100,
    S_SCROLL = 7'b0001000,
    S_BLANK  = 7'b0010000,
    S_CLEAR  = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t                      state;
  logic [tce_pkg::ADDR_W-1:0]  cnt;
  logic [tce_pkg::ROW_W-1:0]   cur_row;
  logic [tce_pkg::COL_W-1:0]   cur_col;
  logic                        status_r;
  logic [7:0]                  rchar_r;
  logic                        is_get;
  logic [tce_pkg::ADDR_W-1:0]  idx_r;
  logic                        pw_en;
  logic                        pw_copy;
  logic [tce_pkg::ADDR_W-1:0]  pw_addr;
  logic [tce_pkg::CELL_W-1:0]  pw_data;

  logic                        accept;
  logic                        in_range;
  logic                        last_row;
  logic                        last_col;
  logic [tce_pkg::COL_W-1:0]   bs_col;
  logic [tce_pkg::ADDR_W-1:0]  cur_idx;
  logic [tce_pkg::ADDR_W-1:0]  bs_idx;
  logic [tce_pkg::ADDR_W-1:0]  in_idx;

  // The last write of the clearing pass after reset lands in the first idle cycle,
  // so no cell read may start before it.
  assign item_stall = (state != S_IDLE) || pw_en;
  assign accept     = item_valid && !item_stall;
  assign in_range   = (row_in < tce_pkg::ROW_W'(tce_pkg::SCREEN_ROWS)) &&
                      (col_in < tce_pkg::COL_W'(tce_pkg::SCREEN_COLUMNS));
  assign last_row   = (cur_row == tce_pkg::ROW_W'(tce_pkg::SCREEN_ROWS - 1));
  assign last_col   = (cur_col == tce_pkg::COL_W'(tce_pkg::SCREEN_COLUMNS - 1));
  assign bs_col     = cur_col - 1'b1;
  assign cur_idx    = tce_pkg::cell_index(cur_row, cur_col);
  assign bs_idx     = tce_pkg::cell_index(cur_row, bs_col);
  assign in_idx     = tce_pkg::cell_index(row_in, col_in);

  // Scroll reads run one row ahead of the delayed copy writes.
  always_comb begin
    if (state == S_SCROLL) begin
      raddr = tce_pkg::ADDR_W'(cnt + tce_pkg::ADDR_W'(tce_pkg::SCREEN_COLUMNS));
    end else if (opcode == tce_pkg::OP_READ_CELL) begin
      raddr = in_idx;
    end else begin
      raddr = bs_idx;
    end
  end

  // All store writes go out in the cycle after they are decided.
  always_comb begin
    wr.en   = pw_en;
    wr.addr = pw_addr;
    wr.data = pw_copy ? rdata : pw_data;
  end

  assign res_valid     = (state == S_DONE) && out_free;
  assign res.status    = status_r;
  assign res.read_char = rchar_r;
  assign res.row       = cur_row;
  assign res.col       = cur_col;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_INIT;
      cnt     <= '0;
      cur_row <= '0;
      cur_col <= '0;
      pw_en   <= 1'b0;
      pw_copy <= 1'b0;
    end else begin
      pw_en   <= 1'b0;
      pw_copy <= 1'b0;
      unique case (state) inside
        S_INIT, S_CLEAR: begin
          pw_en   <= 1'b1;
          pw_addr <= cnt;
          pw_data <= tce_pkg::DEFAULT_CELL;
          if (cnt == tce_pkg::ADDR_W'(tce_pkg::LAST_CELL)) begin
            cnt   <= '0;
            state <= (state == S_INIT) ? S_IDLE : S_DONE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_IDLE: begin
          if (accept) begin
            status_r <= 1'b0;
            rchar_r  <= 8'h00;
            is_get   <= (opcode == tce_pkg::OP_READ_CELL);
            idx_r    <= bs_idx;
            state    <= S_DONE;
            unique case (opcode)
              tce_pkg::OP_PUT_BYTE: begin
                if (char_code == tce_pkg::CHAR_NL) begin
                  cur_col <= '0;
                  if (last_row) begin
                    cnt   <= '0;
                    state <= S_SCROLL;
                  end else begin
                    cur_row <= cur_row + 1'b1;
                  end
                end else if (char_code == tce_pkg::CHAR_CR) begin
                  cur_col <= '0;
                end else if (char_code == tce_pkg::CHAR_BS) begin
                  if (cur_col != '0) begin
                    cur_col <= bs_col;
                    state   <= S_READ;
                  end
                end else begin
                  pw_en   <= 1'b1;
                  pw_addr <= cur_idx;
                  pw_data <= {text_attr, char_code};
                  if (last_col) begin
                    cur_col <= '0;
                    if (last_row) begin
                      cnt   <= '0;
                      state <= S_SCROLL;
                    end else begin
                      cur_row <= cur_row + 1'b1;
                    end
                  end else begin
                    cur_col <= cur_col + 1'b1;
                  end
                end
              end
              tce_pkg::OP_SET_CURSOR: begin
                if (in_range) begin
                  cur_row <= row_in;
                  cur_col <= col_in;
                end else begin
                  status_r <= 1'b1;
                end
              end
              tce_pkg::OP_DRAW_CHAR: begin
                if (in_range) begin
                  pw_en   <= 1'b1;
                  pw_addr <= in_idx;
                  pw_data <= {cell_attribute, char_code};
                end else begin
                  status_r <= 1'b1;
                end
              end
              tce_pkg::OP_READ_CELL: begin
                if (in_range) begin
                  state <= S_READ;
                end else begin
                  status_r <= 1'b1;
                end
              end
              tce_pkg::OP_CLEAR: begin
                cur_row <= '0;
                cur_col <= '0;
                cnt     <= '0;
                state   <= S_CLEAR;
              end
              default: begin
              end
            endcase
          end
        end
        S_READ: begin
          if (is_get) begin
            rchar_r <= rdata[7:0];
          end else begin
            // Backspace keeps the attribute byte of the cell.
            pw_en   <= 1'b1;
            pw_addr <= idx_r;
            pw_data <= {rdata[15:8], tce_pkg::SPACE_CHAR};
          end
          state <= S_DONE;
        end
        S_SCROLL: begin
          pw_en   <= 1'b1;
          pw_copy <= 1'b1;
          pw_addr <= cnt;
          cnt     <= cnt + 1'b1;
          if (cnt == tce_pkg::ADDR_W'(tce_pkg::COPY_LAST)) begin
            state <= S_BLANK;
          end
        end
        S_BLANK: begin
          pw_en   <= 1'b1;
          pw_addr <= cnt;
          pw_data <= {text_attr, tce_pkg::SPACE_CHAR};
          if (cnt == tce_pkg::ADDR_W'(tce_pkg::LAST_CELL)) begin
            cnt     <= '0;
            cur_row <= tce_pkg::ROW_W'(tce_pkg::SCREEN_ROWS - 1);
            state   <= S_DONE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_INIT;
        end
      endcase
    end
  end

endmodule

>>> test/text_console_checker.sv
// Checker for the text console engine: predicts every result and compares it on arrival.
`timescale 1ns / 100ps

module text_console_checker
  import tce_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  logic             item_stall,
  input  logic [2:0]       opcode,
  input  logic [7:0]       char_code,
  input  logic [ROW_W-1:0] row_in,
  input  logic [COL_W-1:0] col_in,
  input  logic [7:0]       cell_attribute,
  input  logic             result_valid,
  input  logic             result_stall,
  input  logic             status,
  input  logic [7:0]       read_char,
  input  logic [ROW_W-1:0] cursor_row,
  input  logic [COL_W-1:0] cursor_col,
  input  logic [15:0]      cursor_location,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic             pready,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output int               mismatch_count,
  output int               pending_results
);

  localparam int PRINT_CAP = 200;

  typedef struct packed {
    logic             status;
    logic [7:0]       read_char;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [15:0]      location;
  } console_result_t;

  logic [CELL_W-1:0] screen [CELL_COUNT];
  logic [ROW_W-1:0]  row_now;
  logic [COL_W-1:0]  col_now;
  logic [7:0]        text_attr;
  logic              cursor_on;
  console_result_t   console_results_q[$];
  int                results_seen;

  initial begin
    mismatch_count  = 0;
    pending_results = 0;
    results_seen    = 0;
  end

  task automatic report(input string msg);
    if (mismatch_count < PRINT_CAP)
      $display("%0t: result %0d: %s", $realtime, results_seen, msg);
    mismatch_count++;
  endtask

  task automatic home_and_blank();
    for (int i = 0; i < CELL_COUNT; i++)
      screen[i] = DEFAULT_CELL;
    row_now = '0;
    col_now = '0;
  endtask

  // Moving off the last row shifts every row up and blanks the bottom one.
  task automatic line_feed();
    if (int'(row_now) + 1 >= SCREEN_ROWS) begin
      for (int i = 0; i < (SCREEN_ROWS - 1) * SCREEN_COLUMNS; i++)
        screen[i] = screen[i + SCREEN_COLUMNS];
      for (int c = 0; c < SCREEN_COLUMNS; c++)
        screen[(SCREEN_ROWS - 1) * SCREEN_COLUMNS + c] = {text_attr, SPACE_CHAR};
      row_now = ROW_W'(SCREEN_ROWS - 1);
    end else begin
      row_now++;
    end
    col_now = '0;
  endtask

  task automatic apply_item(input logic [2:0] op, input logic [7:0] ch,
                            input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c,
                            input logic [7:0] attr, output console_result_t res);
    int   cursor_idx;
    int   target_idx;
    logic on_screen;
    on_screen  = (int'(r) < SCREEN_ROWS) && (int'(c) < SCREEN_COLUMNS);
    target_idx = int'(r) * SCREEN_COLUMNS + int'(c);
    cursor_idx = int'(row_now) * SCREEN_COLUMNS + int'(col_now);
    res = '0;
    case (op)
      OP_PUT_BYTE: begin
        if (ch == CHAR_NL) begin
          line_feed();
        end else if (ch == CHAR_CR) begin
          col_now = '0;
        end else if (ch == CHAR_BS) begin
          // Backspace only blanks the character; the attribute stays.
          if (col_now != '0) begin
            col_now--;
            screen[cursor_idx - 1][7:0] = SPACE_CHAR;
          end
        end else begin
          screen[cursor_idx] = {text_attr, ch};
          col_now++;
          if (int'(col_now) >= SCREEN_COLUMNS)
            line_feed();
        end
      end
      OP_SET_CURSOR: begin
        if (on_screen) begin
          row_now = r;
          col_now = c;
        end else begin
          res.status = 1'b1;
        end
      end
      OP_DRAW_CHAR: begin
        if (on_screen)
          screen[target_idx] = {attr, ch};
        else
          res.status = 1'b1;
      end
      OP_READ_CELL: begin
        if (on_screen)
          res.read_char = screen[target_idx][7:0];
        else
          res.status = 1'b1;
      end
      OP_CLEAR: begin
        home_and_blank();
      end
      default: begin
      end
    endcase
    res.row = row_now;
    res.col = col_now;
    res.location = cursor_on ? 16'(int'(row_now) * SCREEN_COLUMNS + int'(col_now))
                             : HIDDEN_LOCATION;
  endtask

  task automatic compare_result(input console_result_t want);
    if (status !== want.status)
      report($sformatf("status expected %0d, got %0d", want.status, status));
    if (read_char !== want.read_char)
      report($sformatf("read_char expected %02h, got %02h", want.read_char, read_char));
    if (cursor_row !== want.row)
      report($sformatf("cursor_row expected %0d, got %0d", want.row, cursor_row));
    if (cursor_col !== want.col)
      report($sformatf("cursor_col expected %0d, got %0d", want.col, cursor_col));
    if (cursor_location !== want.location)
      report($sformatf("cursor_location expected %04h, got %04h",
                       want.location, cursor_location));
  endtask

  always @(posedge clk) begin
    console_result_t res;
    if (rst) begin
      home_and_blank();
      text_attr = DEFAULT_ATTR;
      cursor_on = 1'b1;
      console_results_q.delete();
    end else begin
      if (result_valid && !result_stall) begin
        if (console_results_q.size() == 0) begin
          report("result arrived with nothing expected");
        end else begin
          compare_result(console_results_q.pop_front());
        end
        results_seen++;
      end
      if (item_valid && !item_stall) begin
        apply_item(opcode, char_code, row_in, col_in, cell_attribute, res);
        console_results_q.push_back(res);
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_TEXT_ATTR)
          text_attr = pwdata[7:0];
        else
          cursor_on = pwdata[0];
      end
    end
    pending_results <= console_results_q.size();
  end

endmodule

>>> test/text_console_engine_tb.sv
// Testbench top for the text console engine: clock, reset, stimulus and the verdict.
`timescale 1ns / 100ps

module text_console_engine_tb;
  import tce_pkg::*;

  localparam int         WATCHDOG_LIMIT = 20000;
  localparam int         RANDOM_PHASES  = 8;
  localparam int         PHASE_ITEMS    = 110;
  localparam int         DRAIN_CYCLES   = 100;
  localparam logic [2:0] OP_LAST_CODE   = 3'd7;

  logic             clk            = 1'b0;
  logic             rst            = 1'b1;
  logic             item_valid     = 1'b0;
  logic             item_stall;
  logic [2:0]       opcode         = '0;
  logic [7:0]       char_code      = '0;
  logic [ROW_W-1:0] row_in         = '0;
  logic [COL_W-1:0] col_in         = '0;
  logic [7:0]       cell_attribute = '0;
  logic             result_valid;
  logic             result_stall   = 1'b0;
  logic             status;
  logic [7:0]       read_char;
  logic [ROW_W-1:0] cursor_row;
  logic [COL_W-1:0] cursor_col;
  logic [15:0]      cursor_location;
  logic             psel           = 1'b0;
  logic             penable        = 1'b0;
  logic             pwrite         = 1'b0;
  logic [2:0]       paddr          = '0;
  logic [31:0]      pwdata         = '0;
  logic [31:0]      prdata;
  logic             pready;

  int mismatch_count;
  int pending_results;
  int gap_pct     = 0;
  int stall_pct   = 0;
  int quiet_cycles = 0;

  always #4 clk = ~clk;

  text_console_engine uut (.*);

  text_console_checker console_model (.*);

  always @(posedge clk) begin
    if (rst)
      result_stall <= 1'b0;
    else
      result_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Called right after a rising edge; returns at the edge where the item is taken.
  task automatic send_item(input logic [2:0] op, input logic [7:0] ch,
                           input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c,
                           input logic [7:0] attr);
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      item_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    item_valid     <= 1'b1;
    opcode         <= op;
    char_code      <= ch;
    row_in         <= r;
    col_in         <= c;
    cell_attribute <= attr;
    do @(posedge clk); while (item_stall);
  endtask

  task automatic wait_all_results();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  task automatic config_write(input logic reg_index, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_index, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // On-screen picks favor the bottom rows and both screen edges, where wraps
  // and scrolls happen.
  task automatic pick_cell(input bit on_screen, output logic [ROW_W-1:0] r,
                           output logic [COL_W-1:0] c);
    if (on_screen) begin
      if ($urandom_range(1)) begin
        r = ROW_W'($urandom_range(SCREEN_ROWS - 1, SCREEN_ROWS - 3));
        c = $urandom_range(1) ? COL_W'($urandom_range(15))
                              : COL_W'($urandom_range(SCREEN_COLUMNS - 1, SCREEN_COLUMNS - 8));
      end else begin
        r = ROW_W'($urandom_range(SCREEN_ROWS - 1));
        c = COL_W'($urandom_range(SCREEN_COLUMNS - 1));
      end
    end else begin
      r = ROW_W'($urandom_range((1 << ROW_W) - 1));
      c = COL_W'($urandom_range((1 << COL_W) - 1));
      case ($urandom_range(2))
        0: r = ROW_W'($urandom_range((1 << ROW_W) - 1, SCREEN_ROWS));
        1: c = COL_W'($urandom_range((1 << COL_W) - 1, SCREEN_COLUMNS));
        default: begin
          r = ROW_W'($urandom_range((1 << ROW_W) - 1, SCREEN_ROWS));
          c = COL_W'($urandom_range((1 << COL_W) - 1, SCREEN_COLUMNS));
        end
      endcase
    end
  endtask

  task automatic random_item();
    int               pick;
    int               sel;
    bit               on_screen;
    logic [2:0]       op;
    logic [7:0]       ch;
    logic [7:0]       attr;
    logic [ROW_W-1:0] r;
    logic [COL_W-1:0] c;
    pick = $urandom_range(99);
    ch   = 8'($urandom_range(255));
    attr = 8'($urandom_range(255));
    r    = ROW_W'($urandom_range((1 << ROW_W) - 1));
    c    = COL_W'($urandom_range((1 << COL_W) - 1));
    if (pick < 45) begin
      op  = OP_PUT_BYTE;
      sel = $urandom_range(99);
      if (sel < 8)
        ch = CHAR_NL;
      else if (sel < 13)
        ch = CHAR_CR;
      else if (sel < 20)
        ch = CHAR_BS;
    end else if (pick < 60) begin
      op        = OP_SET_CURSOR;
      on_screen = ($urandom_range(9) < 8);
      pick_cell(on_screen, r, c);
      if (on_screen && $urandom_range(3) == 0)
        r = ROW_W'(SCREEN_ROWS - 1);
    end else if (pick < 75) begin
      op = OP_DRAW_CHAR;
      pick_cell($urandom_range(19) < 17, r, c);
    end else if (pick < 93) begin
      op = OP_READ_CELL;
      pick_cell($urandom_range(19) < 17, r, c);
    end else if (pick < 95) begin
      op = OP_CLEAR;
    end else begin
      op = 3'($urandom_range(int'(OP_LAST_CODE), int'(OP_CLEAR) + 1));
    end
    send_item(op, ch, r, c, attr);
  endtask

  initial begin
    logic [7:0] attr_setting;
    logic       shown_setting;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset settings: corners, off-screen targets,
    // wrap, backspace, carriage return, scrolls, clear and unused codes.
    send_item(OP_READ_CELL,  8'h00, 5'd0,  7'd0,   8'h00);
    send_item(OP_DRAW_CHAR,  8'hFF, 5'd0,  7'd0,   8'hFF);
    send_item(OP_READ_CELL,  8'h00, 5'd0,  7'd0,   8'h00);
    send_item(OP_DRAW_CHAR,  8'h00, 5'd24, 7'd79,  8'h00);
    send_item(OP_READ_CELL,  8'hFF, 5'd24, 7'd79,  8'hFF);
    send_item(OP_READ_CELL,  8'h00, 5'd25, 7'd0,   8'h00);
    send_item(OP_READ_CELL,  8'h00, 5'd0,  7'd80,  8'h00);
    send_item(OP_DRAW_CHAR,  8'h55, 5'd31, 7'd127, 8'hAA);
    send_item(OP_SET_CURSOR, 8'h00, 5'd31, 7'd127, 8'h00);
    send_item(OP_SET_CURSOR, 8'h00, 5'd0,  7'd78,  8'h00);
    send_item(OP_PUT_BYTE,   8'h41, 5'd31, 7'd127, 8'hFF);
    send_item(OP_PUT_BYTE,   8'hFF, 5'd0,  7'd0,   8'h00);
    send_item(OP_PUT_BYTE,   CHAR_BS, 5'd0, 7'd0,  8'h00);
    send_item(OP_PUT_BYTE,   8'h00, 5'd0,  7'd0,   8'h00);
    send_item(OP_PUT_BYTE,   CHAR_BS, 5'd0, 7'd0,  8'h00);
    send_item(OP_READ_CELL,  8'h00, 5'd1,  7'd0,   8'h00);
    send_item(OP_PUT_BYTE,   8'h78, 5'd0,  7'd0,   8'h00);
    send_item(OP_PUT_BYTE,   CHAR_CR, 5'd0, 7'd0,  8'h00);
    send_item(OP_SET_CURSOR, 8'h00, 5'd24, 7'd79,  8'h00);
    send_item(OP_PUT_BYTE,   8'h5A, 5'd0,  7'd0,   8'h00);
    send_item(OP_PUT_BYTE,   CHAR_NL, 5'd0, 7'd0,  8'h00);
    send_item(OP_SET_CURSOR, 8'h00, 5'd23, 7'd5,   8'h00);
    send_item(OP_PUT_BYTE,   CHAR_NL, 5'd0, 7'd0,  8'h00);
    send_item(OP_READ_CELL,  8'h00, 5'd22, 7'd79,  8'h00);
    send_item(OP_CLEAR,      8'h00, 5'd0,  7'd0,   8'h00);
    send_item(OP_LAST_CODE,  8'hFF, 5'd31, 7'd127, 8'hFF);

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_all_results();
      repeat (10) @(posedge clk);
      attr_setting  = 8'($urandom_range(255));
      shown_setting = 1'($urandom_range(1));
      case (phase)
        0: begin
          attr_setting  = 8'h00;
          shown_setting = 1'b0;
        end
        1: begin
          attr_setting  = 8'hFF;
          shown_setting = 1'b1;
        end
        5: begin
          attr_setting  = 8'hFF;
          shown_setting = 1'b0;
        end
        6: begin
          attr_setting  = 8'h00;
          shown_setting = 1'b1;
        end
        default: begin
        end
      endcase
      config_write(REG_TEXT_ATTR, 32'(attr_setting));
      config_write(REG_CURSOR_SHOWN, 32'(shown_setting));
      case (phase % 4)
        0: begin
          gap_pct = 0;
          stall_pct <= 0;
        end
        1: begin
          gap_pct = 59;
          stall_pct <= 0;
        end
        2: begin
          gap_pct = 0;
          stall_pct <= 59;
        end
        default: begin
          gap_pct = 23;
          stall_pct <= 23;
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Now and then the sender holds off until the screen has caught up.
        if ($urandom_range(99) == 0)
          wait_all_results();
        random_item();
      end
    end

    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

>>> files.f
rtl/tce_pkg.sv
rtl/tce_cell_ram.sv
rtl/tce_ctrl.sv
rtl/text_console_engine.sv
test/text_console_checker.sv
test/text_console_engine_tb.sv
